// File: rtl/pcsgf_pkg.sv
// ----------------------------------------------------------------------------
// pcsgf_pkg: shared types and constants
// Operation codes, field widths and the per-task memory entry layout for the
// per-CPU slot / global FIFO scheduler.
// ----------------------------------------------------------------------------
package pcsgf_pkg;

    localparam int OP_W   = 2;
    localparam int CPU_W  = 2;
    localparam int TASK_W = 6;
    localparam int AFF_W  = 4;
    localparam int CNT_W  = 7;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [CPU_W-1:0]  cpu_t;
    typedef logic [TASK_W-1:0] task_t;
    typedef logic [AFF_W-1:0]  aff_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam op_t OP_ENQ  = 2'd0;
    localparam op_t OP_DEQ  = 2'd1;
    localparam op_t OP_PICK = 2'd2;

    localparam cnt_t CNT_MAX = 7'd127;

    // One word of the task memory
    typedef struct packed {
        logic queued;
        aff_t mask;
        cpu_t home;
    } tent_t;

endpackage

// File: rtl/pcsgf_if.sv
// ----------------------------------------------------------------------------
// pcsgf request / response channels
// Valid/ready channels carrying scheduler requests and their results.
// ----------------------------------------------------------------------------
interface pcsgf_req_if;
    import pcsgf_pkg::*;

    logic  valid;
    logic  ready;
    op_t   operation;
    cpu_t  cpu;
    task_t task_req;
    aff_t  affinity;

    modport source (output valid, output operation, output cpu, output task_req,
                    output affinity, input ready);
    modport sink   (input valid, input operation, input cpu, input task_req,
                    input affinity, output ready);
endinterface

interface pcsgf_rsp_if;
    import pcsgf_pkg::*;

    logic  valid;
    logic  ready;
    logic  picked_valid;
    task_t picked_task;
    logic  migrated;
    logic  ignored;
    cnt_t  running_count;

    modport source (output valid, output picked_valid, output picked_task,
                    output migrated, output ignored, output running_count,
                    input ready);
    modport sink   (input valid, input picked_valid, input picked_task,
                    input migrated, input ignored, input running_count,
                    output ready);
endinterface

// File: rtl/per_cpu_slot_global_fifo_scheduler.sv
// ----------------------------------------------------------------------------
// per_cpu_slot_global_fifo_scheduler
// One run slot per CPU plus a shared FIFO of waiting tasks, kept as a doubly
// linked list in next/prev link memories; per-task flags in a task memory.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------
//  req     | in  | operation, cpu, task_req, affinity
//  rsp     | out | picked_valid, picked_task, migrated, ignored,
//          |     | running_count
//
//  Each request: the accept edge issues the memory reads, and the execute
//  state does the read-modify-write and loads the result register.
//  The execute cycle waits while a previous result is still unread.
//  After reset a clearing pass wipes every entry of the task memory;
//  req.ready stays low during it.
// ----------------------------------------------------------------------------
module per_cpu_slot_global_fifo_scheduler #(
    parameter int NUM_CPUS  = 4,
    parameter int NUM_TASKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    pcsgf_req_if.sink   req,
    pcsgf_rsp_if.source rsp
);
    import pcsgf_pkg::*;

    localparam int TW = $clog2(NUM_TASKS);
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    typedef logic [TW-1:0] tidx_t;

    // memories
    tent_t tmem    [NUM_TASKS];
    tidx_t next_mem[NUM_TASKS];
    tidx_t prev_mem[NUM_TASKS];

    tent_t tmem_rd_reg;
    tidx_t next_rd_reg;
    tidx_t prev_rd_reg;

    logic  tmem_we;
    tidx_t tmem_waddr;
    tent_t tmem_wdata;
    logic  next_we;
    tidx_t next_waddr;
    tidx_t next_wdata;
    logic  prev_we;
    tidx_t prev_waddr;
    tidx_t prev_wdata;
    tidx_t rd_addr;

    // control
    logic [1:0] state_reg, state_next;
    tidx_t      clr_cnt_reg;
    logic       accept;
    logic       exec_go;

    // captured request
    op_t   op_reg;
    cpu_t  cpu_reg;
    task_t task_reg;
    aff_t  aff_reg;

    // scheduler state
    logic [NUM_CPUS-1:0] slot_full_reg, slot_full_next;
    tidx_t               slot_task_reg [NUM_CPUS];
    tidx_t               slot_task_next[NUM_CPUS];
    cnt_t                cnt_reg [NUM_CPUS];
    cnt_t                cnt_next[NUM_CPUS];
    tidx_t               head_reg, head_next;
    tidx_t               tail_reg, tail_next;
    logic                empty_reg, empty_next;

    // result register
    logic  out_valid_reg;
    logic  res_valid_reg, res_valid;
    task_t res_task_reg;
    tidx_t res_task;
    logic  res_mig_reg, res_mig;
    logic  res_ign_reg, res_ign;
    cnt_t  res_cnt_reg, res_cnt;

    // execute-stage helpers
    logic                cpu_ok;
    logic                task_ok;
    logic [CW-1:0]       ci;
    tidx_t               ti;
    cnt_t                cur_cnt;
    cnt_t                new_cnt;
    logic [NUM_CPUS-1:0] hit;
    logic                t_wr;
    tent_t               t_wdata;

    assign accept  = req.valid && req.ready;
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign req.ready = (state_reg == ST_IDLE);

    // pick reads the FIFO head, everything else reads the requested task; prev memory always reads the requested task
    assign rd_addr = (req.operation == OP_PICK) ? head_reg : TW'(req.task_req);

    always_ff @(posedge clk)
    begin
        if (tmem_we)
            tmem[tmem_waddr] <= tmem_wdata;
        if (accept)
            tmem_rd_reg <= tmem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (accept)
            next_rd_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (accept)
            prev_rd_reg <= prev_mem[TW'(req.task_req)];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.operation;
            cpu_reg  <= req.cpu;
            task_reg <= req.task_req;
            aff_reg  <= req.affinity;
        end
    end

    // state machine
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == TW'(NUM_TASKS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // execute: read-modify-write of one request
    assign cpu_ok  = int'(cpu_reg) < NUM_CPUS;
    assign task_ok = int'(task_reg) < NUM_TASKS;
    assign ci      = CW'(cpu_reg);
    assign ti      = TW'(task_reg);
    assign cur_cnt = cnt_reg[ci];

    always_comb
    begin
        for (int i = 0; i < NUM_CPUS; i++)
            hit[i] = slot_full_reg[i] && (slot_task_reg[i] == ti);
    end

    always_comb
    begin
        slot_full_next = slot_full_reg;
        slot_task_next = slot_task_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        new_cnt        = cur_cnt;
        t_wr           = 1'b0;
        t_wdata        = tmem_rd_reg;
        next_we        = 1'b0;
        next_waddr     = tail_reg;
        next_wdata     = ti;
        prev_we        = 1'b0;
        prev_waddr     = ti;
        prev_wdata     = tail_reg;
        res_valid      = 1'b0;
        res_task       = '0;
        res_mig        = 1'b0;
        res_ign        = 1'b0;

        if (exec_go && cpu_ok)
        begin
            case (op_reg)
                OP_ENQ:
                begin
                    if (!task_ok || tmem_rd_reg.queued)
                    begin
                        res_ign = 1'b1;
                    end
                    else
                    begin
                        t_wr    = 1'b1;
                        t_wdata = '{queued: 1'b1, mask: aff_reg, home: cpu_reg};
                        if (!slot_full_reg[ci])
                        begin
                            slot_full_next[ci] = 1'b1;
                            slot_task_next[ci] = ti;
                        end
                        else if (empty_reg)
                        begin
                            head_next  = ti;
                            tail_next  = ti;
                            empty_next = 1'b0;
                        end
                        else
                        begin
                            // append behind the current tail
                            next_we    = 1'b1;
                            next_waddr = tail_reg;
                            next_wdata = ti;
                            prev_we    = 1'b1;
                            prev_waddr = ti;
                            prev_wdata = tail_reg;
                            tail_next  = ti;
                        end
                        if (cur_cnt != CNT_MAX)
                            new_cnt = cur_cnt + 1'b1;
                    end
                end
                OP_DEQ:
                begin
                    if (!task_ok || !tmem_rd_reg.queued)
                    begin
                        res_ign = 1'b1;
                    end
                    else
                    begin
                        t_wr           = 1'b1;
                        t_wdata.queued = 1'b0;
                        if (|hit)
                        begin
                            // a queued task sits in at most one slot
                            slot_full_next = slot_full_reg & ~hit;
                        end
                        else if (!empty_reg)
                        begin
                            if (ti == head_reg && ti == tail_reg)
                            begin
                                empty_next = 1'b1;
                            end
                            else if (ti == head_reg)
                            begin
                                head_next = next_rd_reg;
                            end
                            else if (ti == tail_reg)
                            begin
                                tail_next = prev_rd_reg;
                            end
                            else
                            begin
                                next_we    = 1'b1;
                                next_waddr = prev_rd_reg;
                                next_wdata = next_rd_reg;
                                prev_we    = 1'b1;
                                prev_waddr = next_rd_reg;
                                prev_wdata = prev_rd_reg;
                            end
                        end
                        if (cur_cnt != '0)
                            new_cnt = cur_cnt - 1'b1;
                    end
                end
                OP_PICK:
                begin
                    if (slot_full_reg[ci])
                    begin
                        res_valid = 1'b1;
                        res_task  = slot_task_reg[ci];
                    end
                    else if (!empty_reg && tmem_rd_reg.mask[cpu_reg])
                    begin
                        if (head_reg == tail_reg)
                            empty_next = 1'b1;
                        else
                            head_next = next_rd_reg;
                        slot_full_next[ci] = 1'b1;
                        slot_task_next[ci] = head_reg;
                        if (tmem_rd_reg.home != cpu_reg)
                        begin
                            res_mig      = 1'b1;
                            t_wr         = 1'b1;
                            t_wdata.home = cpu_reg;
                        end
                        res_valid = 1'b1;
                        res_task  = head_reg;
                    end
                end
                default:
                begin
                end
            endcase
            cnt_next[ci] = new_cnt;
        end
    end

    assign res_cnt = cpu_ok ? new_cnt : '0;

    // task memory port: clearing pass, then the execute stage
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            tmem_we    = 1'b1;
            tmem_waddr = clr_cnt_reg;
            tmem_wdata = '0;
        end
        else
        begin
            tmem_we    = t_wr;
            tmem_waddr = (op_reg == OP_PICK) ? head_reg : ti;
            tmem_wdata = t_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_full_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                slot_task_reg[i] <= '0;
                cnt_reg[i]       <= '0;
            end
        end
        else if (exec_go)
        begin
            slot_full_reg <= slot_full_next;
            slot_task_reg <= slot_task_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec_go)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            res_valid_reg <= res_valid;
            res_task_reg  <= TASK_W'(res_task);
            res_mig_reg   <= res_mig;
            res_ign_reg   <= res_ign;
            res_cnt_reg   <= res_cnt;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.picked_valid  = res_valid_reg;
    assign rsp.picked_task   = res_task_reg;
    assign rsp.migrated      = res_mig_reg;
    assign rsp.ignored       = res_ign_reg;
    assign rsp.running_count = res_cnt_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request accepted during clearing pass");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execute");

    a_exec_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg)
        else $error("executed request produced no result beat");

    a_link_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (next_we || prev_we) |-> exec_go)
        else $error("link memory written outside execute");

    a_pick_xor_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.ignored && rsp.picked_valid) &&
                      (!rsp.migrated || rsp.picked_valid))
        else $error("inconsistent result flags");
`endif

endmodule

// File: bench/tb_per_cpu_slot_global_fifo_scheduler.sv
// ----------------------------------------------------------------------------
// tb_per_cpu_slot_global_fifo_scheduler
// Self-checking bench for the per-CPU slot / shared FIFO scheduler. A driver
// feeds requests from a backlog queue, a shadow scheduler predicts each
// result, and a monitor checks every response beat against it. The run
// covers directed corner cases, random traffic under three idle patterns,
// a long response back-pressure stretch and count saturation.
// ----------------------------------------------------------------------------
module tb_per_cpu_slot_global_fifo_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import pcsgf_pkg::*;

    localparam int NUM_CPUS       = 4;
    localparam int NUM_TASKS      = 64;
    localparam op_t OP_UNUSED     = 2'd3;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_LIMIT    = 3000;
    localparam int TAIL_CYCLES    = 20;
    localparam int SATURATE_LOOPS = 130;

    typedef struct packed {
        op_t   operation;
        cpu_t  cpu;
        task_t tsk;
        aff_t  affinity;
    } sched_req_t;

    typedef struct packed {
        logic       drain_first;   // hold this beat until all results are back
        sched_req_t beat;
    } backlog_item_t;

    typedef struct packed {
        logic  picked_valid;
        task_t picked_task;
        logic  migrated;
        logic  ignored;
        cnt_t  running_count;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       drv_valid = 1'b0;
    sched_req_t drv_req   = '0;
    logic       rsp_ready = 1'b0;

    pcsgf_req_if req_ch ();
    pcsgf_rsp_if rsp_ch ();

    assign req_ch.valid     = drv_valid;
    assign req_ch.operation = drv_req.operation;
    assign req_ch.cpu       = drv_req.cpu;
    assign req_ch.task_req  = drv_req.tsk;
    assign req_ch.affinity  = drv_req.affinity;
    assign rsp_ch.ready     = rsp_ready;

    per_cpu_slot_global_fifo_scheduler #(
        .NUM_CPUS  (NUM_CPUS),
        .NUM_TASKS (NUM_TASKS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow scheduler
    // ------------------------------------------------------------------
    bit    run_slot_busy [NUM_CPUS];
    task_t run_slot_task [NUM_CPUS];
    bit    on_queue      [NUM_TASKS];
    task_t link_next     [NUM_TASKS];
    task_t link_prev     [NUM_TASKS];
    task_t wait_head;
    task_t wait_tail;
    bit    wait_empty = 1'b1;
    aff_t  aff_mask      [NUM_TASKS];
    cpu_t  home_cpu      [NUM_TASKS];
    cnt_t  queued_count  [NUM_CPUS] = '{default: '0};

    function automatic sched_result_t run_scheduler_step(sched_req_t r);
        sched_result_t res;
        bit            found;
        task_t         p;
        task_t         n;
        task_t         h;
        res = '0;
        p = link_prev[r.tsk];
        n = link_next[r.tsk];
        case (r.operation)
            OP_ENQ:
            begin
                if (on_queue[r.tsk])
                begin
                    res.ignored = 1'b1;
                end
                else
                begin
                    aff_mask[r.tsk] = r.affinity;
                    home_cpu[r.tsk] = r.cpu;
                    on_queue[r.tsk] = 1'b1;
                    if (!run_slot_busy[r.cpu])
                    begin
                        run_slot_busy[r.cpu] = 1'b1;
                        run_slot_task[r.cpu] = r.tsk;
                    end
                    else if (wait_empty)
                    begin
                        wait_head  = r.tsk;
                        wait_tail  = r.tsk;
                        wait_empty = 1'b0;
                    end
                    else
                    begin
                        link_next[wait_tail] = r.tsk;
                        link_prev[r.tsk]     = wait_tail;
                        wait_tail            = r.tsk;
                    end
                    if (queued_count[r.cpu] != CNT_MAX)
                        queued_count[r.cpu] = queued_count[r.cpu] + 1'b1;
                end
            end
            OP_DEQ:
            begin
                if (!on_queue[r.tsk])
                begin
                    res.ignored = 1'b1;
                end
                else
                begin
                    found = 1'b0;
                    // any CPU's slot may hold it, not just the addressed one
                    for (int i = 0; i < NUM_CPUS; i++)
                    begin
                        if (!found && run_slot_busy[i] && run_slot_task[i] == r.tsk)
                        begin
                            run_slot_busy[i] = 1'b0;
                            found = 1'b1;
                        end
                    end
                    if (!found && !wait_empty)
                    begin
                        if (r.tsk == wait_head && r.tsk == wait_tail)
                            wait_empty = 1'b1;
                        else if (r.tsk == wait_head)
                            wait_head = n;
                        else if (r.tsk == wait_tail)
                            wait_tail = p;
                        else
                        begin
                            link_next[p] = n;
                            link_prev[n] = p;
                        end
                    end
                    on_queue[r.tsk] = 1'b0;
                    if (queued_count[r.cpu] != '0)
                        queued_count[r.cpu] = queued_count[r.cpu] - 1'b1;
                end
            end
            OP_PICK:
            begin
                if (run_slot_busy[r.cpu])
                begin
                    res.picked_valid = 1'b1;
                    res.picked_task  = run_slot_task[r.cpu];
                end
                else if (!wait_empty && aff_mask[wait_head][r.cpu])
                begin
                    h = wait_head;
                    if (h == wait_tail)
                        wait_empty = 1'b1;
                    else
                        wait_head = link_next[h];
                    run_slot_busy[r.cpu] = 1'b1;
                    run_slot_task[r.cpu] = h;
                    if (home_cpu[h] != r.cpu)
                    begin
                        res.migrated = 1'b1;
                        home_cpu[h]  = r.cpu;
                    end
                    res.picked_valid = 1'b1;
                    res.picked_task  = h;
                end
            end
            default:
            begin
            end
        endcase
        res.running_count = queued_count[r.cpu];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    backlog_item_t request_backlog [$];
    sched_result_t sched_outcomes [$];
    int            sent_cnt = 0;
    int            got_cnt = 0;
    int            mismatch_count = 0;
    int            src_idle_pct = 0;
    int            snk_idle_pct = 0;
    int            hold_kick = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int            quiet_cycles = 0;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 50)
            $display("[mismatch] @%0t beat %0d: %s", $time, got_cnt, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : req_driver
        bit accepted;
        bit offer;
        if (rst_n)
        begin
            accepted = drv_valid && req_ch.ready;
            if (accepted)
            begin
                sched_outcomes.push_back(run_scheduler_step(drv_req));
                void'(request_backlog.pop_front());
                sent_cnt <= sent_cnt + 1;
            end
            if (!drv_valid || accepted)
            begin
                offer = request_backlog.size() != 0 &&
                        $urandom_range(99) >= src_idle_pct;
                if (offer && request_backlog[0].drain_first &&
                    (accepted || sent_cnt != got_cnt))
                    offer = 1'b0;
                drv_valid <= offer;
                if (offer)
                    drv_req <= request_backlog[0].beat;
            end
        end
    end

    // ------------------------------------------------------------------
    // Response monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_monitor
        sched_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ready)
            begin
                got_cnt <= got_cnt + 1;
                if (sched_outcomes.size() == 0)
                begin
                    report_mismatch("response beat with no request outstanding");
                end
                else
                begin
                    want = sched_outcomes.pop_front();
                    if (rsp_ch.picked_valid !== want.picked_valid)
                        report_mismatch($sformatf("picked_valid got %0b want %0b",
                                        rsp_ch.picked_valid, want.picked_valid));
                    if (rsp_ch.picked_task !== want.picked_task)
                        report_mismatch($sformatf("picked_task got %0d want %0d",
                                        rsp_ch.picked_task, want.picked_task));
                    if (rsp_ch.migrated !== want.migrated)
                        report_mismatch($sformatf("migrated got %0b want %0b",
                                        rsp_ch.migrated, want.migrated));
                    if (rsp_ch.ignored !== want.ignored)
                        report_mismatch($sformatf("ignored got %0b want %0b",
                                        rsp_ch.ignored, want.ignored));
                    if (rsp_ch.running_count !== want.running_count)
                        report_mismatch($sformatf("running_count got %0d want %0d",
                                        rsp_ch.running_count, want.running_count));
                end
            end
            rsp_ready <= hold_left == 0 && $urandom_range(99) >= snk_idle_pct;
        end
    end

    // long back-pressure stretch, armed from the stimulus process
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (drv_valid && req_ch.ready) || (rsp_ch.valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    bit gen_queued [NUM_TASKS];   // generator's view of which tasks are queued

    task automatic push_req(input op_t op, input cpu_t c, input task_t t,
                            input aff_t a, input bit drain);
        backlog_item_t item;
        item.drain_first    = drain;
        item.beat.operation = op;
        item.beat.cpu       = c;
        item.beat.tsk       = t;
        item.beat.affinity  = a;
        request_backlog.push_back(item);
        if (op == OP_ENQ)
            gen_queued[t] = 1'b1;
        else if (op == OP_DEQ)
            gen_queued[t] = 1'b0;
    endtask

    function automatic task_t find_task(input bit want_queued);
        int start;
        task_t t;
        start = $urandom_range(NUM_TASKS - 1);
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            t = task_t'((start + i) % NUM_TASKS);
            if (gen_queued[t] == want_queued)
                return t;
        end
        return task_t'($urandom_range(NUM_TASKS - 1));
    endfunction

    task automatic push_random(input int count, input bit drain_first_item);
        int    roll;
        op_t   op;
        cpu_t  c;
        task_t t;
        aff_t  a;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(99);
            c    = cpu_t'($urandom_range(NUM_CPUS - 1));
            t    = task_t'($urandom_range(NUM_TASKS - 1));
            a    = ($urandom_range(99) < 25) ? 4'hF : aff_t'($urandom_range(15));
            if (roll < 32)
            begin
                op = OP_ENQ;
                if ($urandom_range(99) < 85)
                    t = find_task(1'b0);
            end
            else if (roll < 64)
            begin
                op = OP_DEQ;
                if ($urandom_range(99) < 80)
                    t = find_task(1'b1);
            end
            else if (roll < 96)
                op = OP_PICK;
            else
                op = OP_UNUSED;
            push_req(op, c, t, a, drain_first_item && k == 0);
        end
    endtask

    task automatic wait_for_quiet();
        while (request_backlog.size() != 0 || sent_cnt != got_cnt)
            @(posedge clk);
    endtask

    initial
    begin
        task_t t;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // phase 1: slow receiver
        src_idle_pct = 17;
        snk_idle_pct = 80;
        push_req(OP_UNUSED, 2'd0, 6'd0,  4'h0, 1'b0);
        push_req(OP_PICK,   2'd0, 6'd0,  4'h0, 1'b0);  // nothing anywhere
        push_req(OP_DEQ,    2'd0, 6'd0,  4'h0, 1'b0);  // not queued, count stays 0
        push_req(OP_ENQ,    2'd3, 6'd63, 4'hF, 1'b0);  // into slot 3
        push_req(OP_ENQ,    2'd1, 6'd63, 4'h5, 1'b0);  // already queued
        push_req(OP_ENQ,    2'd3, 6'd0,  4'h0, 1'b0);  // first FIFO entry
        push_req(OP_ENQ,    2'd3, 6'd21, 4'h2, 1'b0);
        push_req(OP_ENQ,    2'd3, 6'd42, 4'h1, 1'b0);
        push_req(OP_ENQ,    2'd3, 6'd5,  4'hF, 1'b0);
        push_req(OP_PICK,   2'd3, 6'd0,  4'h0, 1'b0);  // slot hit
        push_req(OP_PICK,   2'd1, 6'd0,  4'h0, 1'b0);  // head mask blocks cpu 1
        push_req(OP_DEQ,    2'd0, 6'd0,  4'h0, 1'b0);  // unlink head, count floor
        push_req(OP_PICK,   2'd1, 6'd0,  4'h0, 1'b0);  // head moves, migrates
        push_req(OP_PICK,   2'd1, 6'd0,  4'h0, 1'b0);
        push_req(OP_ENQ,    2'd3, 6'd7,  4'hF, 1'b0);
        push_req(OP_DEQ,    2'd3, 6'd5,  4'h0, 1'b0);  // middle of the FIFO
        push_req(OP_DEQ,    2'd3, 6'd7,  4'h0, 1'b0);  // FIFO tail
        push_req(OP_DEQ,    2'd0, 6'd63, 4'h0, 1'b0);  // another CPU's slot
        push_req(OP_PICK,   2'd3, 6'd0,  4'h0, 1'b0);  // mask lacks cpu 3
        push_req(OP_PICK,   2'd0, 6'd0,  4'h0, 1'b0);  // last FIFO entry leaves
        push_req(OP_DEQ,    2'd0, 6'd42, 4'h0, 1'b0);  // own slot
        push_req(OP_ENQ,    2'd0, 6'd1,  4'hF, 1'b0);
        push_req(OP_ENQ,    2'd0, 6'd2,  4'hF, 1'b0);
        push_req(OP_DEQ,    2'd0, 6'd1,  4'h0, 1'b0);
        push_req(OP_PICK,   2'd0, 6'd0,  4'h0, 1'b0);  // from FIFO, same home
        push_req(OP_PICK,   2'd2, 6'd0,  4'h0, 1'b0);
        push_random(200, 1'b0);
        wait_for_quiet();

        // phase 2: slow sender, with one beat held until results drain
        src_idle_pct = 80;
        snk_idle_pct = 17;
        push_random(120, 1'b0);
        push_random(100, 1'b1);
        wait_for_quiet();

        // phase 3: no idling; the receiver stalls while requests pile up
        src_idle_pct = 0;
        snk_idle_pct = 0;
        push_random(60, 1'b0);
        hold_kick = hold_kick + 1;
        push_random(100, 1'b0);
        wait_for_quiet();

        // drive cpu 0 count to its ceiling and cpu 1 to its floor
        t = find_task(1'b0);
        for (int k = 0; k < SATURATE_LOOPS; k++)
        begin
            push_req(OP_ENQ, 2'd0, t, aff_t'($urandom_range(15)), 1'b0);
            push_req(OP_DEQ, 2'd1, t, aff_t'($urandom_range(15)), 1'b0);
        end
        push_random(40, 1'b0);
        wait_for_quiet();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sched_outcomes.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                            sched_outcomes.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
